### sv/start_stop_xor_packet_deframer_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the start/stop XOR packet deframer
// Clocked property checks with synchronous reset disable; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef START_STOP_XOR_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define START_STOP_XOR_PACKET_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define SSXD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ssxd assertion failed");
// cons must hold in the clock cycle after ante
`define SSXD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssxd assertion failed");
`else
`define SSXD_ASSERT(label, clk, rst, prop)
`define SSXD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### sv/ssxd_pkg.sv
// ----------------------------------------------------------------------------
// ssxd_pkg
// Shared types and constants of the start/stop XOR packet deframer.
// ----------------------------------------------------------------------------
package ssxd_pkg;

  typedef logic [7:0] byte_t;

  localparam int PAYLOAD_LEN = 8;
  localparam int POS_W       = 4;

  typedef logic [POS_W-1:0] pos_t;

  // frame position codes; 1..PAYLOAD_LEN mean "next byte is payload byte n"
  localparam pos_t POS_IDLE  = 4'd0;
  localparam pos_t POS_FIRST = 4'd1;
  localparam pos_t POS_LAST  = 4'd8;
  localparam pos_t POS_CHECK = 4'd9;
  localparam pos_t POS_CLOSE = 4'd10;

  localparam int CFG_INDEX_W = 1;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_START_MARKER = 1'd0;
  localparam cfg_index_t REG_STOP_MARKER  = 1'd1;

  localparam byte_t START_MARKER_RESET = 8'hAA;
  localparam byte_t STOP_MARKER_RESET  = 8'h55;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic shift;     // payload byte accepted, advance the cell chain
    logic emit;      // good packet closed, load the output register
    logic at_close;  // next byte is the closing byte
  } ctrl_t;

endpackage

### sv/ssxd_if.sv
// ----------------------------------------------------------------------------
// ssxd_rx_if / ssxd_pkt_if
// Valid/ready channels: received bytes in, decoded packets out.
// ----------------------------------------------------------------------------
interface ssxd_rx_if;
  logic             valid;
  logic             ready;
  ssxd_pkg::byte_t  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ssxd_pkt_if;
  logic             valid;
  logic             ready;
  ssxd_pkg::byte_t  joystick_x;
  ssxd_pkg::byte_t  joystick_y;
  ssxd_pkg::byte_t  button_a;
  ssxd_pkg::byte_t  button_b;
  ssxd_pkg::byte_t  button_c;
  ssxd_pkg::byte_t  button_d;
  ssxd_pkg::byte_t  button_e;
  ssxd_pkg::byte_t  button_k;

  modport source (output valid, output joystick_x, output joystick_y,
                  output button_a, output button_b, output button_c,
                  output button_d, output button_e, output button_k,
                  input ready);
  modport sink   (input valid, input joystick_x, input joystick_y,
                  input button_a, input button_b, input button_c,
                  input button_d, input button_e, input button_k,
                  output ready);
endinterface

### sv/ssxd_cell.sv
// ----------------------------------------------------------------------------
// ssxd_cell
// One payload byte cell; takes its neighbour's byte on shift.
// ----------------------------------------------------------------------------
module ssxd_cell (
  input  logic            clk,
  input  logic            shift,
  input  ssxd_pkg::byte_t d_in,
  output ssxd_pkg::byte_t q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d_in;
    end
  end

endmodule

### sv/ssxd_seq.sv
// ----------------------------------------------------------------------------
// ssxd_seq
// Frame position counter and running XOR check.
// ----------------------------------------------------------------------------
`include "start_stop_xor_packet_deframer_core_defines.svh"

module ssxd_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  ssxd_pkg::byte_t rx_byte,
  input  ssxd_pkg::byte_t start_marker,
  input  ssxd_pkg::byte_t stop_marker,
  output ssxd_pkg::ctrl_t ctrl
);

  ssxd_pkg::pos_t  pos;
  ssxd_pkg::pos_t  pos_next;
  ssxd_pkg::byte_t xor_acc;      // payload XOR, then XORed with the check byte
  ssxd_pkg::byte_t xor_acc_next;
  logic            in_payload;

  assign in_payload = (pos >= ssxd_pkg::POS_FIRST) && (pos <= ssxd_pkg::POS_LAST);

  always_comb begin
    pos_next     = pos;
    xor_acc_next = xor_acc;
    if (take) begin
      case (pos)
        ssxd_pkg::POS_CHECK: begin
          xor_acc_next = xor_acc ^ rx_byte;
          pos_next     = ssxd_pkg::POS_CLOSE;
        end
        ssxd_pkg::POS_CLOSE: begin
          pos_next = ssxd_pkg::POS_IDLE;
        end
        default: begin
          if (in_payload) begin
            xor_acc_next = xor_acc ^ rx_byte;
            pos_next     = pos + 4'd1;
          end else begin
            // idle, and unused codes behave as idle
            xor_acc_next = '0;
            pos_next     = (rx_byte == start_marker) ? ssxd_pkg::POS_FIRST
                                                     : ssxd_pkg::POS_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= ssxd_pkg::POS_IDLE;
    end else begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    xor_acc <= xor_acc_next;
  end

  assign ctrl.shift    = take && in_payload;
  assign ctrl.at_close = (pos == ssxd_pkg::POS_CLOSE);
  assign ctrl.emit     = take && ctrl.at_close && (rx_byte == stop_marker)
                         && (xor_acc == '0);

  `SSXD_ASSERT(a_pos_range, clk, rst, pos <= ssxd_pkg::POS_CLOSE)
  `SSXD_ASSERT(a_emit_at_close, clk, rst,
               !ctrl.emit || (take && pos == ssxd_pkg::POS_CLOSE))
  `SSXD_ASSERT_NEXT(a_close_to_idle, clk, rst,
                    take && pos == ssxd_pkg::POS_CLOSE, pos == ssxd_pkg::POS_IDLE)
  `SSXD_ASSERT_NEXT(a_start_opens, clk, rst,
                    take && pos == ssxd_pkg::POS_IDLE && rx_byte == start_marker,
                    pos == ssxd_pkg::POS_FIRST)

endmodule

### sv/start_stop_xor_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// start_stop_xor_packet_deframer_core
// Start/stop byte deframer with XOR checksum. Channel rx takes one received
// byte per item; channel pkt gives one item of eight payload bytes per good
// packet. Frame: start marker, eight payload bytes, XOR check byte, stop.
// Rate: one byte per cycle while rx.ready is high; the position counter
// takes every accepted byte and the cell chain every payload byte. A
// packet is shown on pkt in the cycle after its closing byte is accepted.
// The closing byte is held off (rx.ready low) only while a packet waits in
// the output register and pkt.ready is low; all other bytes are taken even
// while pkt stalls. Bad packets and bytes outside a frame are dropped.
// Markers are written through cfg_we/cfg_index/cfg_data; the user must do
// so only while idle, the block does not check. Reset (rst, synchronous):
// position to idle, output empty, markers default (start 0xAA, stop 0x55).
// ----------------------------------------------------------------------------
module start_stop_xor_packet_deframer_core (
  input  logic                   clk,
  input  logic                   rst,
  ssxd_rx_if.sink                rx,
  ssxd_pkt_if.source             pkt,
  input  logic                   cfg_we,
  input  ssxd_pkg::cfg_index_t   cfg_index,
  input  ssxd_pkg::byte_t        cfg_data
);

  ssxd_pkg::byte_t start_marker;
  ssxd_pkg::byte_t stop_marker;
  ssxd_pkg::ctrl_t ctrl;
  logic            take;

  // cell chain: byte enters cell 0, first payload byte ends in the last cell
  ssxd_pkg::byte_t cell_q [ssxd_pkg::PAYLOAD_LEN];

  // marker registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= ssxd_pkg::START_MARKER_RESET;
      stop_marker  <= ssxd_pkg::STOP_MARKER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ssxd_pkg::REG_START_MARKER: start_marker <= cfg_data;
        ssxd_pkg::REG_STOP_MARKER:  stop_marker  <= cfg_data;
        default: ;
      endcase
    end
  end

  // only the closing byte can need the output register
  assign rx.ready = !ctrl.at_close || !pkt.valid || pkt.ready;
  assign take     = rx.valid && rx.ready;

  ssxd_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .rx_byte      (rx.rx_byte),
    .start_marker (start_marker),
    .stop_marker  (stop_marker),
    .ctrl         (ctrl)
  );

  for (genvar i = 0; i < ssxd_pkg::PAYLOAD_LEN; i++) begin : g_cell
    if (i == 0) begin : g_head
      ssxd_cell u_cell (
        .clk   (clk),
        .shift (ctrl.shift),
        .d_in  (rx.rx_byte),
        .q     (cell_q[i])
      );
    end else begin : g_body
      ssxd_cell u_cell (
        .clk   (clk),
        .shift (ctrl.shift),
        .d_in  (cell_q[i-1]),
        .q     (cell_q[i])
      );
    end
  end

  // output register; lets the next frame fill the cells while a packet waits
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt.valid <= 1'b0;
    end else if (ctrl.emit) begin
      pkt.valid <= 1'b1;
    end else if (pkt.ready) begin
      pkt.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      pkt.joystick_x <= cell_q[7];
      pkt.joystick_y <= cell_q[6];
      pkt.button_a   <= cell_q[5];
      pkt.button_b   <= cell_q[4];
      pkt.button_c   <= cell_q[3];
      pkt.button_d   <= cell_q[2];
      pkt.button_e   <= cell_q[1];
      pkt.button_k   <= cell_q[0];
    end
  end

endmodule
